// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phn_pkg.sv =====
package phn_pkg;

   // Phase word: 2^32 per turn
   localparam int unsigned PHASE_W      = 32;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // Gain products are scaled down by this many bits
   localparam int unsigned GAIN_SHIFT = 15;

   // Register map
   localparam int unsigned       CSR_INDEX_W      = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_FREQ = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ALPHA  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_BETA   = 2'd2;

   // Cosine table generation constants, Q2.30
   localparam longint ONE_Q30     = longint'(1) << 30;
   localparam longint HALF_PI_Q30 = 1686629713;

   // Step strobes from the sequencer to the loop datapath
   typedef struct packed {
      logic load_pilot;
      logic mul_err;
      logic shift_err;
      logic mul_gain;
      logic cap_first;
      logic cap_second;
      logic cap_third;
      logic update;
   } phn_ctrl_type;

   // Cosine over the first quadrant, u in quarter-turn units of 2^30
   function automatic longint quarter_cos(input logic [31:0] u, input longint amp);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] q;
      longint      t;
      x  = ({32'd0, u} * 64'(HALF_PI_Q30)) >> 30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      // Horner form of the degree-12 Taylor series, innermost term first
      for (int i = 0; i < 6; i++) begin
         p = (x2 * 64'(t)) >> 30;
         case (i)
            0: q = p / 64'd132;
            1: q = p / 64'd90;
            2: q = p / 64'd56;
            3: q = p / 64'd30;
            4: q = p / 64'd12;
            default: q = p / 64'd2;
         endcase
         t = ONE_Q30 - longint'(q);
         if (t < 0) begin
            t = 0;
         end
      end
      return longint'((64'(t) * 64'(amp) + 64'd536870912) >> 30);
   endfunction

   // Full-turn cosine by quarter-wave symmetry
   function automatic longint rom_cos(input logic [31:0] phase, input longint amp);
      logic [31:0] frac;
      logic [31:0] u;
      longint      v;
      frac = {2'b00, phase[29:0]};
      u    = phase[30] ? (QUARTER_TURN - frac) : frac;
      v    = quarter_cos(u, amp);
      return (phase[31] ^ phase[30]) ? -v : v;
   endfunction

endpackage

// ===== rtl/phn_ram.sv =====
module phn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/phn_loop.sv =====
module phn_loop #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  phn_pkg::phn_ctrl_type               ctrl,
   input  logic [SAMPLE_BITS-1:0]              pilot_sample,
   input  logic [SAMPLE_BITS-1:0]              rd_data,
   input  logic                                csr_we,
   input  logic [phn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_data,
   output logic [phn_pkg::PHASE_W-1:0]         phase,
   output logic [SAMPLE_BITS-1:0]              carrier_first,
   output logic [SAMPLE_BITS-1:0]              carrier_second,
   output logic [SAMPLE_BITS-1:0]              carrier_third
);

   localparam int PROD_W  = 2 * SAMPLE_BITS;
   localparam int ERR_W   = SAMPLE_BITS + 2;
   localparam int GPROD_W = 33 + ERR_W;
   localparam int TERM_W  = GPROD_W - phn_pkg::GAIN_SHIFT;
   localparam int SUM_W   = ((TERM_W > 32) ? TERM_W : 32) + 1;
   localparam logic signed [SUM_W-1:0] FREQ_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SUM_W-1:0] FREQ_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

   logic [31:0]                 phase_ff, phase_in;
   logic signed [31:0]          freq_ff, freq_in;
   logic [31:0]                 alpha_ff, beta_ff;
   logic signed [SAMPLE_BITS-1:0] pilot_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [PROD_W:0]      neg_prod;
   logic signed [ERR_W-1:0]     err_ff;
   logic signed [GPROD_W-1:0]   alpha_prod_ff, alpha_prod_in;
   logic signed [GPROD_W-1:0]   beta_prod_ff, beta_prod_in;
   logic signed [TERM_W-1:0]    pterm, iterm;
   logic signed [SUM_W-1:0]     freq_ext, step_sum, freq_sum;
   logic [SAMPLE_BITS-1:0]      first_ff, second_ff, third_ff;

   // Phase error product and gain products
   assign prod_in       = pilot_ff * $signed(rd_data);
   assign neg_prod      = -$signed({prod_ff[PROD_W-1], prod_ff});
   assign alpha_prod_in = $signed({1'b0, alpha_ff}) * err_ff;
   assign beta_prod_in  = $signed({1'b0, beta_ff}) * err_ff;

   // Scale gain terms down, rounding toward minus infinity
   assign pterm    = alpha_prod_ff[GPROD_W-1:phn_pkg::GAIN_SHIFT];
   assign iterm    = beta_prod_ff[GPROD_W-1:phn_pkg::GAIN_SHIFT];
   assign freq_ext = {{(SUM_W-32){freq_ff[31]}}, freq_ff};
   assign step_sum = freq_ext + {{(SUM_W-TERM_W){pterm[TERM_W-1]}}, pterm};
   assign freq_sum = freq_ext + {{(SUM_W-TERM_W){iterm[TERM_W-1]}}, iterm};

   // Advance phase and saturate frequency; a center_frequency write reloads the frequency
   always_comb begin
      phase_in = phase_ff;
      freq_in  = freq_ff;
      if (ctrl.update) begin
         phase_in = phase_ff + step_sum[31:0];
         if (freq_sum > FREQ_MAX) begin
            freq_in = FREQ_MAX[31:0];
         end else if (freq_sum < FREQ_MIN) begin
            freq_in = FREQ_MIN[31:0];
         end else begin
            freq_in = freq_sum[31:0];
         end
      end
      if (csr_we && (csr_index == phn_pkg::CSR_CENTER_FREQ)) begin
         freq_in = csr_data;
      end
   end

   // Loop state and gains
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         freq_ff  <= '0;
         alpha_ff <= '0;
         beta_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         freq_ff  <= freq_in;
         if (csr_we && (csr_index == phn_pkg::CSR_GAIN_ALPHA)) begin
            alpha_ff <= csr_data;
         end
         if (csr_we && (csr_index == phn_pkg::CSR_GAIN_BETA)) begin
            beta_ff <= csr_data;
         end
      end
   end

   // Datapath registers, each loaded on its own sequencer strobe
   always_ff @(posedge clock) begin
      if (ctrl.load_pilot) begin
         pilot_ff <= $signed(pilot_sample);
      end
      if (ctrl.mul_err) begin
         prod_ff <= prod_in;
      end
      if (ctrl.shift_err) begin
         err_ff <= neg_prod[PROD_W:SAMPLE_BITS-1];
      end
      if (ctrl.mul_gain) begin
         alpha_prod_ff <= alpha_prod_in;
         beta_prod_ff  <= beta_prod_in;
      end
      if (ctrl.cap_first) begin
         first_ff <= rd_data;
      end
      if (ctrl.cap_second) begin
         second_ff <= rd_data;
      end
      if (ctrl.cap_third) begin
         third_ff <= rd_data;
      end
   end

   assign phase          = phase_ff;
   assign carrier_first  = first_ff;
   assign carrier_second = second_ff;
   assign carrier_third  = third_ff;

endmodule

// ===== rtl/pilot_pll_harmonic_nco.sv =====
// Second-order PLL locked to a pilot tone, with a harmonic oscillator output. Each accepted
// pilot sample yields one item holding the cosines of the tracked phase and of twice and
// three times that phase, read from a 2^LUT_ADDR_BITS-entry cosine memory. After reset the
// memory is loaded from its built-in table, during which req_tready stays low; csr writes
// are taken throughout. An item's steps are the four reads (sine, first, second and third
// harmonic) through the single read port of the cosine memory, one per cycle with the error
// and gain multiplies overlapped, then the capture of the last read and the loop update. The
// next item can be taken in the cycle after the result is registered, so items never overlap.
// A result waiting on rsp_tready holds only the final update step. Writing center_frequency
// also reloads the loop frequency; registers are to be written by the user only while the
// block is idle, and the block itself does not enforce this.
module pilot_pll_harmonic_nco #(
   parameter int LUT_ADDR_BITS = 10,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: pilot_sample
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // rsp_tdata: carrier_first, carrier_second, carrier_third
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [phn_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [31:0]                            csr_data
);

   localparam int     LUT_SIZE   = 1 << LUT_ADDR_BITS;
   localparam int     ADDR_SHIFT = 32 - LUT_ADDR_BITS;
   localparam int     ROM_BITS   = LUT_SIZE * SAMPLE_BITS;
   localparam int     RSP_W      = ((3*SAMPLE_BITS+7)/8)*8;
   localparam longint AMPLITUDE  = (longint'(1) << (SAMPLE_BITS-1)) - 1;

   // Build the sampled cosine table at elaboration
   function automatic logic [ROM_BITS-1:0] build_rom();
      logic [ROM_BITS-1:0] rom;
      longint              v;
      rom = '0;
      for (int k = 0; k < LUT_SIZE; k++) begin
         v = phn_pkg::rom_cos(32'(k) << ADDR_SHIFT, AMPLITUDE);
         rom[k*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(v);
      end
      return rom;
   endfunction

   localparam logic [ROM_BITS-1:0] COS_ROM = build_rom();

   typedef enum logic [6:0] {
      ST_FILL      = 7'b0000001,
      ST_IDLE      = 7'b0000010,
      ST_RD_FIRST  = 7'b0000100,
      ST_RD_SECOND = 7'b0001000,
      ST_RD_THIRD  = 7'b0010000,
      ST_RD_LAST   = 7'b0100000,
      ST_UPDATE    = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [LUT_ADDR_BITS-1:0]  fill_cnt_ff, fill_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff;
   phn_pkg::phn_ctrl_type     ctrl;
   logic                      csr_we;
   logic                      req_fire;
   logic                      out_free;
   logic                      ram_we;
   logic [LUT_ADDR_BITS-1:0]  rd_addr;
   logic [SAMPLE_BITS-1:0]    rd_data;
   logic [31:0]               phase;
   logic [31:0]               sine_phase;
   logic [31:0]               third_phase;
   logic [SAMPLE_BITS-1:0]    carrier_first, carrier_second, carrier_third;

   assign csr_ready  = 1'b1;
   assign csr_we     = csr_valid;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Table phases for the quarter-turn-back sine and the third harmonic
   assign sine_phase  = phase - phn_pkg::QUARTER_TURN;
   assign third_phase = phase + {phase[30:0], 1'b0};

   // Sequencer: table fill after reset, then per item one memory read per step and the loop update
   always_comb begin
      state_in    = state_ff;
      fill_cnt_in = fill_cnt_ff;
      ctrl        = '0;
      ram_we      = 1'b0;
      rd_addr     = sine_phase[31 -: LUT_ADDR_BITS];
      case (state_ff)
         ST_FILL: begin
            ram_we      = 1'b1;
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == {LUT_ADDR_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               ctrl.load_pilot = 1'b1;
               state_in        = ST_RD_FIRST;
            end
         end
         ST_RD_FIRST: begin
            rd_addr      = phase[31 -: LUT_ADDR_BITS];
            ctrl.mul_err = 1'b1;
            state_in     = ST_RD_SECOND;
         end
         ST_RD_SECOND: begin
            rd_addr        = phase[30 -: LUT_ADDR_BITS];
            ctrl.cap_first = 1'b1;
            ctrl.shift_err = 1'b1;
            state_in       = ST_RD_THIRD;
         end
         ST_RD_THIRD: begin
            rd_addr         = third_phase[31 -: LUT_ADDR_BITS];
            ctrl.cap_second = 1'b1;
            ctrl.mul_gain   = 1'b1;
            state_in        = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            ctrl.cap_third = 1'b1;
            state_in       = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               ctrl.update = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // Output register: load on update, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         rsp_data_ff <= RSP_W'({carrier_third, carrier_second, carrier_first});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   phn_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (LUT_SIZE)
   ) u_cos_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_cnt_ff),
      .wr_data (COS_ROM[fill_cnt_ff*SAMPLE_BITS +: SAMPLE_BITS]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   phn_loop #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_loop (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .pilot_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .rd_data        (rd_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .phase          (phase),
      .carrier_first  (carrier_first),
      .carrier_second (carrier_second),
      .carrier_third  (carrier_third)
   );

endmodule

// ===== rtl/phn_checker.sv =====
`include "assert_macros.svh"

module phn_checker #(
   parameter int LUT_ADDR_BITS = 10,
   parameter int SAMPLE_BITS   = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((3*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                               csr_valid,
   input logic                               csr_ready
);

   logic req_fire;
   logic fill_busy;

   assign req_fire  = req_tvalid && req_tready;
   // Busy flag follows reset while both parameters are positive
   assign fill_busy = (LUT_ADDR_BITS > 0) && (SAMPLE_BITS > 0) && reset;

   // Reset empties the output and holds off new items
   `ASSERT_ALWAYS(a_reset_quiet, clock, fill_busy |=> (!rsp_tvalid && !req_tready), "busy after reset")

   // One item in flight: input closes right after an item is taken
   `ASSERT_CLK(a_one_in_flight, clock, reset, req_fire |=> !req_tready, "second item taken early")

   // A fresh result follows the update step, when no item is taken
   `ASSERT_CLK(a_result_after_update, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready), "result without update")

   // A waiting result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result dropped")

   // Configuration port never stalls
   `ASSERT_CLK(a_csr_open, clock, reset, csr_valid |-> csr_ready, "register write stalled")

endmodule

bind pilot_pll_harmonic_nco phn_checker #(
   .LUT_ADDR_BITS (LUT_ADDR_BITS),
   .SAMPLE_BITS   (SAMPLE_BITS)
) u_phn_checker (.*);
